@@ hw/rtl/crc32cz_pkg.sv @@
package crc32cz_pkg;

  localparam int CrcW      = 32;
  localparam int CountBits = 32;

  localparam logic [CrcW-1:0] PolyRefl = 32'h82F6_3B78;
  localparam logic [CrcW-1:0] PolyNorm = 32'h1EDC_6F41;
  // x^8 in reflected bit order
  localparam logic [CrcW-1:0] X8Refl   = 32'h0080_0000;

  localparam logic [1:0] KindSeed = 2'd0;
  localparam logic [1:0] KindByte = 2'd1;
  localparam logic [1:0] KindZero = 2'd2;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_BYTE,
    OP_ZERO,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CrcW-1:0] operand;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  function automatic logic [CrcW-1:0] bitrev32(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

  // x^j mod P, normal bit order; only ever called with constant j
  function automatic logic [CrcW-1:0] x_pow_mod(input int j);
    logic [CrcW-1:0] v;
    v = 32'h0000_0001;
    for (int k = 0; k < j; k++) begin
      v = v[CrcW-1] ? ((v << 1) ^ PolyNorm) : (v << 1);
    end
    return v;
  endfunction

  // GF(2) product mod P, operands and result in reflected order.
  // Carry-less multiply, then fold each high product bit via a constant residue.
  function automatic logic [CrcW-1:0] gf_mul_refl(input logic [CrcW-1:0] a,
                                                  input logic [CrcW-1:0] b);
    logic [CrcW-1:0]   an;
    logic [CrcW-1:0]   bn;
    logic [2*CrcW-2:0] prod;
    logic [2*CrcW-2:0] term;
    logic [CrcW-1:0]   r;
    an   = bitrev32(a);
    bn   = bitrev32(b);
    prod = '0;
    for (int i = 0; i < CrcW; i++) begin
      term = {{(CrcW-1){1'b0}}, an} << i;
      if (bn[i]) prod = prod ^ term;
    end
    r = prod[CrcW-1:0];
    for (int j = CrcW; j < 2*CrcW-1; j++) begin
      if (prod[j]) r = r ^ x_pow_mod(j);
    end
    return bitrev32(r);
  endfunction

  function automatic logic [CrcW-1:0] fold_byte(input logic [CrcW-1:0] crc,
                                                input logic [7:0]      b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-8){1'b0}}, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ PolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/crc32cz_req_if.sv @@
interface crc32cz_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seed;
  logic [7:0]  data_byte;
  logic [31:0] zero_count;

  modport source (output valid, output kind, output seed, output data_byte,
                  output zero_count, input ready);
  modport sink   (input valid, input kind, input seed, input data_byte,
                  input zero_count, output ready);
endinterface

@@ hw/rtl/crc32cz_rsp_if.sv @@
interface crc32cz_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

@@ hw/rtl/crc32cz_front.sv @@
module crc32cz_front (
  input  logic               clk,
  input  logic               rst,
  crc32cz_req_if.sink        req,
  output crc32cz_pkg::cmd_t  cmd,
  output logic               cmd_valid,
  input  logic               cmd_pop
);
  import crc32cz_pkg::*;

  // two-entry command queue
  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       push;

  always_comb begin
    decoded.operand = req.zero_count;
    case (req.kind)
      KindSeed: begin
        decoded.op      = OP_SEED;
        decoded.operand = req.seed;
      end
      KindByte: begin
        decoded.op      = OP_BYTE;
        decoded.operand = {24'h0, req.data_byte};
      end
      KindZero: begin
        decoded.op      = OP_ZERO;
        decoded.operand = req.zero_count;
      end
      default: begin
        decoded.op      = OP_NOP;
      end
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= decoded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)    wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/crc32cz_back.sv @@
module crc32cz_back (
  input  logic               clk,
  input  logic               rst,
  input  crc32cz_pkg::cmd_t  cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  crc32cz_rsp_if.source      rsp
);
  import crc32cz_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic [CrcW-1:0]      crc;
  logic [CrcW-1:0]      crc_next;
  logic [CrcW-1:0]      power;
  logic [CrcW-1:0]      power_next;
  logic [CountBits-1:0] rem;
  logic [CountBits-1:0] rem_next;
  logic                 out_valid;
  logic [CrcW-1:0]      out_data;
  logic [CrcW-1:0]      out_data_next;
  logic                 out_load;
  logic                 slot_free;
  logic                 last_step;
  logic [CrcW-1:0]      mul_crc;
  logic [CrcW-1:0]      mul_pow;
  logic [CrcW-1:0]      stepped;

  assign slot_free = !out_valid || rsp.ready;
  assign last_step = (rem[CountBits-1:1] == '0);
  assign mul_crc   = gf_mul_refl(power, crc);
  assign mul_pow   = gf_mul_refl(power, power);
  assign stepped   = rem[0] ? mul_crc : crc;

  assign rsp.valid     = out_valid;
  assign rsp.crc_value = out_data;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.op == OP_ZERO) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_step && slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_pop       = 1'b0;
    out_load      = 1'b0;
    out_data_next = crc;
    crc_next      = crc;
    power_next    = power;
    rem_next      = rem;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_ZERO: begin
              cmd_pop    = 1'b1;
              power_next = X8Refl;
              rem_next   = cmd.operand[CountBits-1:0];
            end
            OP_SEED: begin
              if (slot_free) begin
                cmd_pop       = 1'b1;
                out_load      = 1'b1;
                crc_next      = cmd.operand;
                out_data_next = cmd.operand;
              end
            end
            OP_BYTE: begin
              if (slot_free) begin
                cmd_pop       = 1'b1;
                out_load      = 1'b1;
                crc_next      = fold_byte(crc, cmd.operand[7:0]);
                out_data_next = fold_byte(crc, cmd.operand[7:0]);
              end
            end
            default: begin
              if (slot_free) begin
                cmd_pop  = 1'b1;
                out_load = 1'b1;
              end
            end
          endcase
        end
      end
      ST_RUN: begin
        if (!last_step) begin
          crc_next   = stepped;
          power_next = mul_pow;
          rem_next   = {1'b0, rem[CountBits-1:1]};
        end else if (slot_free) begin
          crc_next      = stepped;
          out_load      = 1'b1;
          out_data_next = stepped;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      crc   <= crc_next;
      if (out_load)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    power <= power_next;
    rem   <= rem_next;
    if (out_load) out_data <= out_data_next;
  end

endmodule

@@ hw/rtl/crc32c_with_zero_run_append_unit.sv @@
// Running reflected CRC-32C engine (no pre/post inversion) with zero-run append.
// Channels: req carries kind, seed, data_byte and zero_count; rsp returns
//   crc_value, the CRC register after each item. A transfer happens on a
//   rising clk edge with valid and ready both high; every req transfer yields
//   exactly one rsp transfer, in order.
// kind: load seed, fold one data byte, append a run of zero bytes; the
//   unused code just reports the current register.
// Seed, byte and unused items reach rsp through a queue entry and the
//   registered output stage. A zero run takes one square-and-multiply step
//   per cycle, one per bit of zero_count up to its highest set bit, through
//   two parallel GF(2) multipliers in the back end; only the last step stalls.
// Throughput: one seed/byte item per cycle while rsp accepts; a zero run holds
//   the back end for its dispatch and all its steps, while the front queue
//   takes items until both of its entries are full.
// A two-entry command queue decouples the front (accept and classify) from
//   the back (execute); rsp is a registered output stage.
// Reset (rst, synchronous): CRC register cleared to zero, queue emptied,
//   rsp.valid low. When rsp stalls, the result holds in its register, the back
//   end stops before its next result, and req.ready drops once the queue fills.
module crc32c_with_zero_run_append_unit (
  input  logic          clk,
  input  logic          rst,
  crc32cz_req_if.sink   req,
  crc32cz_rsp_if.source rsp
);
  import crc32cz_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // front: accept, classify, queue
  crc32cz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // back: CRC register, byte fold, zero-run sequencer, output stage
  crc32cz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule
